### rtl/ipp_pkg.sv
// ipp_pkg: shared types and constants for the address text parser
// no dependencies; imported by every rtl module of the parser
`timescale 1ns / 1ps

package ipp_pkg;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_MALFORMED   = 2'd1;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;

    localparam logic [16:0] HEX_SAT  = 17'h10000;
    localparam logic [16:0] HEX_MAX  = 17'h0FFFF;
    localparam logic [8:0]  DEC_SAT  = 9'd256;
    localparam logic [8:0]  DEC_MAX  = 9'd255;
    localparam int unsigned NUM_GROUPS = 8;
    localparam logic [2:0]  TAIL_DOTS  = 3'd3;
    localparam logic [2:0]  MAX_DOTS   = 3'd4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [1:0] family;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] address_hi;
        logic [63:0] address_lo;
    } t_result;

    typedef struct packed {
        logic [7:0][15:0] groups;
        logic [3:0][7:0]  octets;
        logic [16:0]      hex_accum;
        logic [8:0]       dec_accum;
        logic [3:0]       groups_before_gap;
        logic [3:0]       groups_after_gap;
        logic [2:0]       dot_count;
        logic             started;
        logic             err;
        logic             gap;
        logic             tail;
        logic             pcolon;
        logic             hasdig;
        logic             nondec;
        logic [1:0]       family;
    } t_parse_state;

endpackage

### rtl/ipp_in_stage.sv
// ipp_in_stage: input register for one character request
// depends on ipp_pkg; advance comes from the parse core
`timescale 1ns / 1ps

module ipp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_ch,
    input  logic           i_last,
    input  logic [1:0]     i_family,
    output logic           o_stall,
    input  logic           i_advance,
    output logic           o_item_valid,
    output ipp_pkg::t_item o_item
);
    import ipp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign o_stall      = r_valid && !i_advance;
    assign load         = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= '{ch: i_ch, last: i_last, family: i_family};
        end
    end

endmodule

### rtl/ipp_parse_core.sv
// ipp_parse_core: parse state registers, per-character update and end-of-string assembly
// depends on ipp_pkg; fed by ipp_in_stage, feeds ipp_out_stage
`timescale 1ns / 1ps

module ipp_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  ipp_pkg::t_item   i_item,
    input  logic             i_out_free,
    output logic             o_advance,
    output logic             o_result_valid,
    output ipp_pkg::t_result o_result
);
    import ipp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;

    function automatic t_parse_state f_dec_digit(input t_parse_state s, input logic [3:0] d);
        t_parse_state r;
        logic [12:0]  v;
        r = s;
        v = 13'(s.dec_accum) * 13'd10 + 13'(d);
        r.dec_accum = (v > 13'(DEC_SAT)) ? DEC_SAT : v[8:0];
        return r;
    endfunction

    function automatic t_parse_state f_store_octet(input t_parse_state s);
        t_parse_state r;
        r = s;
        if (s.dec_accum > DEC_MAX) begin
            r.err = 1'b1;
        end
        if (s.dot_count < MAX_DOTS) begin
            r.octets[s.dot_count[1:0]] = s.dec_accum[7:0];
        end
        r.dec_accum = '0;
        return r;
    endfunction

    function automatic t_parse_state f_dot_count(input t_parse_state s);
        t_parse_state r;
        r = s;
        if (s.dot_count >= TAIL_DOTS) begin
            r.err = 1'b1;
        end
        if (s.dot_count < MAX_DOTS) begin
            r.dot_count = s.dot_count + 3'd1;
        end
        return r;
    endfunction

    function automatic t_parse_state f_commit_group(input t_parse_state s);
        t_parse_state r;
        logic [4:0]   n;
        r = s;
        n = 5'(s.groups_before_gap) + 5'(s.groups_after_gap);
        if (s.hex_accum > HEX_MAX) begin
            r.err = 1'b1;
        end
        if (n >= 5'(NUM_GROUPS)) begin
            r.err = 1'b1;
        end else begin
            r.groups[n[2:0]] = s.hex_accum[15:0];
            if (s.gap) begin
                r.groups_after_gap = s.groups_after_gap + 4'd1;
            end else begin
                r.groups_before_gap = s.groups_before_gap + 4'd1;
            end
        end
        r.hex_accum = '0;
        r.dec_accum = '0;
        r.hasdig    = 1'b0;
        r.nondec    = 1'b0;
        return r;
    endfunction

    function automatic t_parse_state f_step(input t_parse_state s, input t_item it);
        t_parse_state r;
        logic         is_dig;
        logic         is_lhex;
        logic         is_uhex;
        logic [3:0]   hv;
        logic [20:0]  hsum;
        logic         lead_single;
        r = s;
        if (!s.started) begin
            r.family  = it.family;
            r.started = 1'b1;
        end
        is_dig  = it.ch inside {[CH_0:CH_9]};
        is_lhex = it.ch inside {[CH_LA:CH_LF]};
        is_uhex = it.ch inside {[CH_UA:CH_UF]};
        hv = is_dig  ? 4'(it.ch - CH_0) :
             is_lhex ? 4'(it.ch - CH_LA + HEX_TEN) : 4'(it.ch - CH_UA + HEX_TEN);
        lead_single = s.pcolon && !s.gap && (s.groups_before_gap == 4'd0);
        hsum = {s.hex_accum, 4'b0000} + 21'(hv);
        case (r.family)
            FAM_V4: begin
                if (is_dig) begin
                    r = f_dec_digit(r, hv);
                end else if (it.ch == CH_DOT) begin
                    r = f_store_octet(r);
                    r = f_dot_count(r);
                end else begin
                    r.err = 1'b1;
                end
            end
            FAM_V6: begin
                if (lead_single && it.ch != CH_COLON) begin
                    r.err = 1'b1;
                end
                if (it.ch == CH_COLON) begin
                    if (r.tail) begin
                        r.err = 1'b1;
                    end else if (r.pcolon) begin
                        if (r.gap) begin
                            r.err = 1'b1;
                        end
                        r.gap = 1'b1;
                    end else if (r.hasdig) begin
                        r = f_commit_group(r);
                    end
                    r.pcolon = 1'b1;
                end else begin
                    r.pcolon = 1'b0;
                    if (it.ch == CH_DOT) begin
                        if (!r.tail) begin
                            if (r.nondec) begin
                                r.err = 1'b1;
                            end
                            r.tail      = 1'b1;
                            r.hex_accum = '0;
                        end
                        r = f_store_octet(r);
                        r = f_dot_count(r);
                    end else if (is_dig || is_lhex || is_uhex) begin
                        if (r.tail) begin
                            if (!is_dig) begin
                                r.err = 1'b1;
                            end else begin
                                r = f_dec_digit(r, hv);
                            end
                        end else begin
                            r.hex_accum = (hsum > 21'(HEX_SAT)) ? HEX_SAT : hsum[16:0];
                            if (r.hex_accum > HEX_MAX) begin
                                r.err = 1'b1;
                            end
                            if (is_dig) begin
                                r = f_dec_digit(r, hv);
                            end else begin
                                r.nondec = 1'b1;
                            end
                            r.hasdig = 1'b1;
                        end
                    end else begin
                        r.err = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_result f_finish(input t_parse_state s);
        t_parse_state     f;
        t_result          res;
        logic [3:0]       n_after;
        logic [4:0]       total;
        logic [3:0]       start;
        logic [3:0]       pi;
        logic [3:0]       src;
        logic [7:0][15:0] g;
        f   = s;
        g   = '0;
        res = '{status: STAT_OK, address_hi: '0, address_lo: '0};
        case (f.family)
            FAM_V4: begin
                f = f_store_octet(f);
                if (f.dot_count != TAIL_DOTS) begin
                    f.err = 1'b1;
                end
                res.address_lo = {32'd0, f.octets[0], f.octets[1], f.octets[2], f.octets[3]};
            end
            FAM_V6: begin
                if (f.pcolon && !(f.gap && f.groups_after_gap == 4'd0 && !f.hasdig)) begin
                    f.err = 1'b1;
                end
                if (f.tail) begin
                    f = f_store_octet(f);
                    if (f.dot_count != TAIL_DOTS) begin
                        f.err = 1'b1;
                    end
                end else if (f.hasdig) begin
                    f = f_commit_group(f);
                end
                n_after = f.groups_after_gap + (f.tail ? 4'd2 : 4'd0);
                total   = 5'(f.groups_before_gap) + 5'(n_after);
                if (f.gap ? (total > 5'd7) : (total != 5'(NUM_GROUPS))) begin
                    f.err = 1'b1;
                end
                start = f.gap ? 4'(NUM_GROUPS) - n_after : f.groups_before_gap;
                for (int p = 0; p < NUM_GROUPS; p++) begin
                    pi  = 4'(p);
                    src = f.groups_before_gap + pi - start;
                    if (pi < f.groups_before_gap) begin
                        g[p] = f.groups[p];
                    end else if (pi >= start && pi < start + f.groups_after_gap) begin
                        g[p] = f.groups[src[2:0]];
                    end
                end
                if (f.tail) begin
                    g[6] = {f.octets[0], f.octets[1]};
                    g[7] = {f.octets[2], f.octets[3]};
                end
                res.address_hi = {g[0], g[1], g[2], g[3]};
                res.address_lo = {g[4], g[5], g[6], g[7]};
            end
            default: begin
            end
        endcase
        if (f.family != FAM_V4 && f.family != FAM_V6) begin
            res.status = STAT_UNSUPPORTED;
        end else if (f.err) begin
            res.status = STAT_MALFORMED;
        end
        if (res.status != STAT_OK) begin
            res.address_hi = '0;
            res.address_lo = '0;
        end
        return res;
    endfunction

    assign o_advance      = i_item_valid && (!i_item.last || i_out_free);
    assign o_result_valid = o_advance && i_item.last;

    always_comb begin
        n_state  = f_step(r_state, i_item);
        o_result = f_finish(n_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (o_advance) begin
            r_state <= i_item.last ? '0 : n_state;
        end
    end

endmodule

### rtl/ipp_out_stage.sv
// ipp_out_stage: result register holding one parsed address until taken
// depends on ipp_pkg; loaded by ipp_parse_core
`timescale 1ns / 1ps

module ipp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ipp_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_address_hi,
    output logic [63:0]      o_address_lo
);
    import ipp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free       = !r_valid || !i_stall;
    assign o_valid      = r_valid;
    assign o_status     = r_result.status;
    assign o_address_hi = r_result.address_hi;
    assign o_address_lo = r_result.address_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/ip_address_text_parser.sv
// ip_address_text_parser: top level of the streaming IPv4/IPv6 text-to-binary parser
// depends on ipp_pkg, ipp_in_stage, ipp_parse_core, ipp_out_stage
//
// usage:
//   input channel: one ASCII character per request on i_ch, i_last marks the final
//   character, i_family (0 IPv4, 1 IPv6, other unsupported) is taken from the first
//   character of each string. a request is taken when i_valid is high and o_stall low.
//   output channel: one result per string, sent with the final character: o_status
//   (0 ok, 1 malformed, 2 unsupported family) and the 128-bit address on
//   o_address_hi / o_address_lo, zero unless status is ok. taken when o_valid is high
//   and i_stall low.
//   throughput: one character per cycle with no gaps between strings, unless the receiver stalls.
//   result path: the final character is registered in the input register, then its
//   result is computed and registered in the result register, where it is presented.
//   receiver stall: the result register holds its value; characters that are not final
//   keep flowing, and a final character waits in the input register until the result
//   register frees, which then stalls the input channel.
//   reset: synchronous, active low; clears both valid flags and all parse state, so the
//   next character starts a new string. no clearing pass is needed.
`timescale 1ns / 1ps

module ip_address_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    input  logic [1:0]  i_family,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_hi,
    output logic [63:0] o_address_lo
);
    import ipp_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    advance;
    logic    out_free;
    logic    result_valid;
    t_result result;

    ipp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .i_family    (i_family),
        .o_stall     (o_stall),
        .i_advance   (advance),
        .o_item_valid(item_valid),
        .o_item      (item)
    );

    ipp_parse_core u_parse_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .i_out_free    (out_free),
        .o_advance     (advance),
        .o_result_valid(result_valid),
        .o_result      (result)
    );

    ipp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (result_valid),
        .i_result    (result),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_address_hi(o_address_hi),
        .o_address_lo(o_address_lo)
    );

endmodule
